// ----- design/lvbm_pkg.sv -----
// lvbm_pkg: shared types and constants for the label volume boundary marker
// used by lvbm_delay and label_volume_boundary_marker; no dependencies
`default_nettype none

package lvbm_pkg;

    // fixed field widths of the ports
    localparam int LABEL_W    = 32;
    localparam int DEPTH_W    = 16;
    localparam int CFG_XY_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // kind of input request (tuser)
    localparam logic ACT_VOXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_Z  = 2'd2;

    // control of one window delay line
    typedef struct packed {
        logic restart;
        logic shift;
    } t_dly_ctrl;

    // which face neighbours lie inside the volume, plus end-of-volume mark
    typedef struct packed {
        logic xm;
        logic xp;
        logic ym;
        logic yp;
        logic zm;
        logic zp;
        logic last;
    } t_edge_flags;

endpackage

`default_nettype wire

// ----- design/lvbm_delay.sv -----
// lvbm_delay: programmable delay line of the voxel window, a ring buffer in memory
// advances one entry per shift; depends on lvbm_pkg
`default_nettype none

module lvbm_delay #(
    parameter int DEPTH = 256,
    parameter int DW    = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire lvbm_pkg::t_dly_ctrl          i_ctrl,
    input  wire logic [$clog2(DEPTH+1)-1:0]   i_len,
    input  wire logic [DW-1:0]                i_din,
    output logic      [DW-1:0]                o_dout
);

    localparam int MEM_D = (DEPTH < 2) ? 2 : DEPTH;
    localparam int AW    = $clog2(MEM_D);
    localparam int LW    = $clog2(DEPTH+1);

    logic [DW-1:0] r_mem [MEM_D];
    logic [AW-1:0] r_ptr;
    logic [DW-1:0] r_rd;
    logic [DW-1:0] r_byp;
    logic [LW-1:0] w_ptr_inc;

    assign w_ptr_inc = LW'(r_ptr) + LW'(1);

    // ring pointer wraps at the programmed length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.restart) begin
            r_ptr <= '0;
        end else if (i_ctrl.shift) begin
            if (w_ptr_inc >= i_len) begin
                r_ptr <= '0;
            end else begin
                r_ptr <= AW'(w_ptr_inc);
            end
        end
    end

    // read the oldest entry and overwrite it with the new one
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_mem[r_ptr] <= i_din;
            r_rd         <= r_mem[r_ptr];
            r_byp        <= i_din;
        end
    end

    // zero length means a plain register stage
    assign o_dout = (i_len == '0) ? r_byp : r_rd;

endmodule

`default_nettype wire

// ----- design/label_volume_boundary_marker.sv -----
// label_volume_boundary_marker: 6-connected label boundary marker over a raster 3D stream
// uses lvbm_pkg and four lvbm_delay window lines
//
//  channel | direction | handshake              | payload
//  s       | in        | i_s_tvalid/o_s_tready  | tdata voxel_label, tuser action
//  m       | out       | o_m_tvalid/i_m_tready  | tdata out_label, tuser boundary_hit,
//          |           |                        | tlast last_voxel
//  cfg     | in        | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// one request per cycle unless stalled; results pass window stage and output register
// window shifts once per voxel until done, then per drain, via single-port ring memories
// synchronous active-low reset clears control; window memories are never cleared
// a stall on the output holds one result in the window stage and one in the output register
// output lags input by one plane; drains flush the last plane after the final voxel
`default_nettype none

module label_volume_boundary_marker #(
    parameter int MAX_X      = 256,
    parameter int MAX_Y      = 256,
    parameter int LABEL_BITS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [lvbm_pkg::LABEL_W-1:0]      i_s_tdata,  // [31:0] voxel_label
    input  wire logic                              i_s_tuser,  // [0] action
    // output stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic      [lvbm_pkg::LABEL_W-1:0]      o_m_tdata,  // [31:0] out_label
    output logic                                   o_m_tuser,  // [0] boundary_hit
    output logic                                   o_m_tlast,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [lvbm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [lvbm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int XW = $clog2(MAX_X+1);
    localparam int YW = $clog2(MAX_Y+1);
    localparam int PW = $clog2(MAX_X*MAX_Y+1);
    localparam int ZW = lvbm_pkg::DEPTH_W;
    localparam int SW = (LABEL_BITS < lvbm_pkg::LABEL_W) ? LABEL_BITS : lvbm_pkg::LABEL_W;
    localparam int RST_W = (MAX_X < 256) ? MAX_X : 256;
    localparam int RST_H = (MAX_Y < 256) ? MAX_Y : 256;

    // configuration registers and derived line lengths
    logic [XW-1:0] r_w, n_w;
    logic [YW-1:0] r_h, n_h;
    logic [ZW-1:0] r_d, n_d;
    logic [PW-1:0] r_len_up, r_len_pl, n_plane;
    logic [XW-1:0] r_len_dn;
    logic          w_cfg_hit;
    logic [lvbm_pkg::CFG_XY_W-1:0] w_cfg_xy;

    // stream positions
    logic [XW-1:0] r_in_x, r_out_x, w_xmax;
    logic [YW-1:0] r_in_y, r_out_y, w_ymax;
    logic [ZW-1:0] r_in_z, r_out_z, w_zmax;
    logic          r_done;

    // handshake and stage control
    logic w_acc, w_drain, w_shift, w_in_step, w_emit, w_in_last;
    logic w_b_free, w_a_move;
    lvbm_pkg::t_dly_ctrl   w_ctrl;
    lvbm_pkg::t_edge_flags w_flg, r_a_flg;
    logic r_a_vld;

    // window taps
    logic [SW-1:0] w_x, r_t0, r_c, r_m1, w_p1, w_pw, w_mw, w_mz;
    logic          w_bnd;

    // output register
    logic                          r_o_vld, r_o_bnd, r_o_last;
    logic [lvbm_pkg::LABEL_W-1:0]  r_o_label;

    function automatic logic differs(input logic [SW-1:0] lab, input logic [SW-1:0] nb);
        differs = (nb != '0) && (nb != lab);
    endfunction

    // register decode and clamping
    always_comb begin
        n_w       = r_w;
        n_h       = r_h;
        n_d       = r_d;
        w_cfg_hit = 1'b0;
        w_cfg_xy  = i_cfg_data[lvbm_pkg::CFG_XY_W-1:0];
        unique case (i_cfg_idx)
            lvbm_pkg::REG_WIDTH_X: begin
                w_cfg_hit = i_cfg_we;
                if (w_cfg_xy == '0) begin
                    n_w = XW'(1);
                end else if (int'(w_cfg_xy) > MAX_X) begin
                    n_w = XW'(MAX_X);
                end else begin
                    n_w = XW'(w_cfg_xy);
                end
            end
            lvbm_pkg::REG_HEIGHT_Y: begin
                w_cfg_hit = i_cfg_we;
                if (w_cfg_xy == '0) begin
                    n_h = YW'(1);
                end else if (int'(w_cfg_xy) > MAX_Y) begin
                    n_h = YW'(MAX_Y);
                end else begin
                    n_h = YW'(w_cfg_xy);
                end
            end
            lvbm_pkg::REG_DEPTH_Z: begin
                w_cfg_hit = i_cfg_we;
                n_d = (i_cfg_data == '0) ? ZW'(1) : i_cfg_data;
            end
            default: begin
                w_cfg_hit = 1'b0;
            end
        endcase
        n_plane = PW'(PW'(n_w) * PW'(n_h));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w      <= XW'(RST_W);
            r_h      <= YW'(RST_H);
            r_d      <= ZW'(1);
            r_len_up <= PW'(RST_W*RST_H - RST_W);
            r_len_pl <= PW'(RST_W*RST_H - 1);
            r_len_dn <= XW'(RST_W - 1);
        end else if (w_cfg_hit) begin
            r_w      <= n_w;
            r_h      <= n_h;
            r_d      <= n_d;
            r_len_up <= n_plane - PW'(n_w);
            r_len_pl <= n_plane - PW'(1);
            r_len_dn <= n_w - XW'(1);
        end
    end

    // request classification
    assign w_b_free  = !r_o_vld || i_m_tready;
    assign w_a_move  = r_a_vld && w_b_free;
    assign o_s_tready = !r_a_vld || w_b_free;
    assign w_acc     = i_s_tvalid && o_s_tready;
    assign w_drain   = (i_s_tuser == lvbm_pkg::ACT_DRAIN);
    assign w_in_step = w_acc && !w_drain && !r_done;
    assign w_shift   = w_acc && (w_drain ? r_done : !r_done);
    assign w_emit    = w_acc && (w_drain ? r_done : (!r_done && (r_in_z != '0)));

    assign w_xmax = r_w - XW'(1);
    assign w_ymax = r_h - YW'(1);
    assign w_zmax = r_d - ZW'(1);
    assign w_in_last = (r_in_x == w_xmax) && (r_in_y == w_ymax) && (r_in_z == w_zmax);

    // in-volume neighbours of the voxel being completed
    always_comb begin
        w_flg.xm   = (r_out_x != '0);
        w_flg.xp   = (r_out_x != w_xmax);
        w_flg.ym   = (r_out_y != '0);
        w_flg.yp   = (r_out_y != w_ymax);
        w_flg.zm   = (r_out_z != '0);
        w_flg.zp   = (r_out_z != w_zmax);
        w_flg.last = !w_flg.xp && !w_flg.yp && !w_flg.zp;
    end

    // raster position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_hit) begin
            r_in_x  <= '0;
            r_in_y  <= '0;
            r_in_z  <= '0;
            r_out_x <= '0;
            r_out_y <= '0;
            r_out_z <= '0;
            r_done  <= 1'b0;
        end else begin
            if (w_in_step) begin
                if (w_in_last) begin
                    r_in_x <= '0;
                    r_in_y <= '0;
                    r_in_z <= '0;
                    r_done <= 1'b1;
                end else if (r_in_x != w_xmax) begin
                    r_in_x <= r_in_x + XW'(1);
                end else begin
                    r_in_x <= '0;
                    if (r_in_y != w_ymax) begin
                        r_in_y <= r_in_y + YW'(1);
                    end else begin
                        r_in_y <= '0;
                        r_in_z <= r_in_z + ZW'(1);
                    end
                end
            end
            if (w_emit) begin
                if (w_flg.last) begin
                    r_out_x <= '0;
                    r_out_y <= '0;
                    r_out_z <= '0;
                    r_done  <= 1'b0;
                end else if (w_flg.xp) begin
                    r_out_x <= r_out_x + XW'(1);
                end else begin
                    r_out_x <= '0;
                    if (w_flg.yp) begin
                        r_out_y <= r_out_y + YW'(1);
                    end else begin
                        r_out_y <= '0;
                        r_out_z <= r_out_z + ZW'(1);
                    end
                end
            end
        end
    end

    // window: newest voxel, centre row taps and delay lines
    assign w_x = w_drain ? '0 : i_s_tdata[SW-1:0];
    assign w_ctrl.restart = w_cfg_hit;
    assign w_ctrl.shift   = w_shift;

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_t0 <= w_x;
            r_c  <= w_p1;
            r_m1 <= r_c;
        end
    end

    // +y neighbour: one plane minus one row behind the newest voxel
    lvbm_delay #(.DEPTH(MAX_X*MAX_Y), .DW(SW)) u_dly_up (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_ctrl),
        .i_len  (r_len_up),
        .i_din  (w_x),
        .o_dout (w_pw)
    );

    // +x neighbour: one plane minus one voxel behind
    lvbm_delay #(.DEPTH(MAX_X*MAX_Y), .DW(SW)) u_dly_ctr (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_ctrl),
        .i_len  (r_len_pl),
        .i_din  (w_x),
        .o_dout (w_p1)
    );

    // -y neighbour: one row behind the centre
    lvbm_delay #(.DEPTH(MAX_X), .DW(SW)) u_dly_dn (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_ctrl),
        .i_len  (r_len_dn),
        .i_din  (r_c),
        .o_dout (w_mw)
    );

    // -z neighbour: one plane behind the centre
    lvbm_delay #(.DEPTH(MAX_X*MAX_Y), .DW(SW)) u_dly_z (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_ctrl),
        .i_len  (r_len_pl),
        .i_din  (r_c),
        .o_dout (w_mz)
    );

    // window stage valid and edge flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_emit) begin
            r_a_vld <= 1'b1;
        end else if (w_a_move) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_a_flg <= w_flg;
        end
    end

    // six neighbour compares on the centre voxel
    assign w_bnd = (r_c != '0) && (
        (r_a_flg.xm && differs(r_c, r_m1)) ||
        (r_a_flg.xp && differs(r_c, w_p1)) ||
        (r_a_flg.ym && differs(r_c, w_mw)) ||
        (r_a_flg.yp && differs(r_c, w_pw)) ||
        (r_a_flg.zm && differs(r_c, w_mz)) ||
        (r_a_flg.zp && differs(r_c, r_t0)));

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_a_move) begin
            r_o_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_move) begin
            r_o_label <= w_bnd ? '0 : lvbm_pkg::LABEL_W'(r_c);
            r_o_bnd   <= w_bnd;
            r_o_last  <= r_a_flg.last;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_label;
    assign o_m_tuser  = r_o_bnd;
    assign o_m_tlast  = r_o_last;

endmodule

`default_nettype wire
